[design/mqrf_pkg.sv]
// Shared types and constants for the multi-queue ring FIFO.
`timescale 1ns / 1ps
package mqrf_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int QUEUE_COUNT_DEF = 4;
  localparam int WORD_BITS_DEF   = 32;

  localparam int KIND_BITS   = 2;
  localparam int SELECT_BITS = 2;
  localparam int STATUS_BITS = 2;
  localparam int LOST_BITS   = 32;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_POP   = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic execute;   // update queue state, access the word store
    logic load_out;  // move the finished result into the output register
  } mqrf_cmd_t;

endpackage

[design/mqrf_ctrl.sv]
// Controller state machine: sequences accept, execute and result hand-off.
`timescale 1ns / 1ps
module mqrf_ctrl
  import mqrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output mqrf_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state_r == S_IDLE) && in_valid;
    cmd.execute  = (state_r == S_EXEC);
    cmd.load_out = (state_r == S_RESP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_RESP;
        end
        S_RESP: begin
          // hold the result until the output register is free
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/mqrf_datapath.sv]
// Datapath: queue pointers, counters, shared word store and result register.
`timescale 1ns / 1ps
module mqrf_datapath
  import mqrf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mqrf_cmd_t              cmd,
  input  logic [KIND_BITS-1:0]   in_kind,
  input  logic [SELECT_BITS-1:0] in_queue_select,
  input  logic [WORD_BITS-1:0]   in_write_word,
  output logic [STATUS_BITS-1:0] out_status,
  output logic [WORD_BITS-1:0]   out_read_word,
  output logic [LOST_BITS-1:0]   out_lost_count
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int AW = (QUEUE_COUNT * QUEUE_DEPTH > 2) ?
                      $clog2(QUEUE_COUNT * QUEUE_DEPTH) : 1;
  localparam int ENTRIES = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int CW = (SELECT_BITS > QW + 1) ? SELECT_BITS : QW + 1;

  // captured request
  logic [KIND_BITS-1:0]   kind_r;
  logic [SELECT_BITS-1:0] sel_r;
  logic [WORD_BITS-1:0]   word_r;

  // per-queue state
  logic [PW-1:0]        head_r    [QUEUE_COUNT];
  logic [PW-1:0]        tail_r    [QUEUE_COUNT];
  logic [FW-1:0]        fill_r    [QUEUE_COUNT];
  logic [LOST_BITS-1:0] dropped_r [QUEUE_COUNT];

  logic [WORD_BITS-1:0] mem [ENTRIES];
  logic [WORD_BITS-1:0] rdata_r;

  // pending result, waiting for the output register
  logic [STATUS_BITS-1:0] pend_status_r;
  logic [LOST_BITS-1:0]   pend_lost_r;
  logic                   pend_pop_r;

  logic [STATUS_BITS-1:0] status_r;
  logic [WORD_BITS-1:0]   read_word_r;
  logic [LOST_BITS-1:0]   lost_r;

  logic                   sel_ok;
  logic [QW-1:0]          qi;
  logic [PW-1:0]          head_cur, tail_cur;
  logic [FW-1:0]          fill_cur;
  logic [LOST_BITS-1:0]   drop_cur;
  logic                   is_full, is_empty;
  logic                   do_push, do_pop, do_clear, do_drop;
  logic [PW-1:0]          ptr;
  logic [AW-1:0]          addr;
  logic [STATUS_BITS-1:0] status_nxt;
  logic [LOST_BITS-1:0]   lost_nxt;

  assign sel_ok   = CW'(sel_r) < CW'(QUEUE_COUNT);
  assign qi       = QW'(sel_r);
  assign head_cur = head_r[qi];
  assign tail_cur = tail_r[qi];
  assign fill_cur = fill_r[qi];
  assign drop_cur = dropped_r[qi];
  assign is_full  = (fill_cur == FW'(QUEUE_DEPTH));
  assign is_empty = (fill_cur == '0);

  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    do_clear   = 1'b0;
    do_drop    = 1'b0;
    status_nxt = ST_OK;
    lost_nxt   = '0;
    if (sel_ok) begin
      lost_nxt = drop_cur;
      unique case (kind_r)
        KIND_POP: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            do_pop = 1'b1;
          end
        end
        KIND_PUSH: begin
          if (is_full) begin
            do_drop    = 1'b1;
            status_nxt = ST_FULL;
            lost_nxt   = drop_cur + 1'b1;
          end else begin
            do_push = 1'b1;
          end
        end
        KIND_CLEAR: begin
          do_clear = 1'b1;
          lost_nxt = '0;
        end
        default: begin
          // unused operation code: no change
        end
      endcase
    end
  end

  assign ptr  = do_push ? tail_cur : head_cur;
  assign addr = AW'(qi) * AW'(QUEUE_DEPTH) + AW'(ptr);

  function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p);
    step_ptr = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      sel_r  <= in_queue_select;
      word_r <= in_write_word;
    end
    if (cmd.execute) begin
      if (do_push) begin
        mem[addr] <= word_r;
      end
      if (do_pop) begin
        rdata_r <= mem[addr];
      end
      pend_status_r <= status_nxt;
      pend_lost_r   <= lost_nxt;
      pend_pop_r    <= do_pop;
    end
    if (cmd.load_out) begin
      status_r    <= pend_status_r;
      read_word_r <= pend_pop_r ? rdata_r : '0;
      lost_r      <= pend_lost_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
        fill_r[i]    <= '0;
        dropped_r[i] <= '0;
      end
    end else if (cmd.execute) begin
      if (do_clear) begin
        head_r[qi]    <= '0;
        tail_r[qi]    <= '0;
        fill_r[qi]    <= '0;
        dropped_r[qi] <= '0;
      end
      if (do_drop) begin
        dropped_r[qi] <= lost_nxt;
      end
      if (do_push) begin
        tail_r[qi] <= step_ptr(tail_cur);
        fill_r[qi] <= fill_cur + 1'b1;
      end
      if (do_pop) begin
        head_r[qi] <= step_ptr(head_cur);
        fill_r[qi] <= fill_cur - 1'b1;
      end
    end
  end

  assign out_status     = status_r;
  assign out_read_word  = read_word_r;
  assign out_lost_count = lost_r;

endmodule

[design/multi_queue_ring_fifo.sv]
// Top level of the multi-queue ring FIFO: controller plus datapath.
//
//  channel | ports                                        | direction
//  in      | in_valid/in_ready, in_kind, in_queue_select, | into block
//          | in_write_word                                |
//  out     | out_valid/out_ready, out_status,             | out of block
//          | out_read_word, out_lost_count                |
//
// Operations run one at a time: accept, execute (pointer update and one
// word store access), then hand-off to the output register.
// A result waiting in the output register does not stop the next transaction
// from being accepted; only the hand-off stalls until that register frees.
// Reset clears all pointers, fill counts and lost counters; the word store is
// not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module multi_queue_ring_fifo
  import mqrf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF,
  parameter int WORD_BITS   = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KIND_BITS-1:0]   in_kind,
  input  logic [SELECT_BITS-1:0] in_queue_select,
  input  logic [WORD_BITS-1:0]   in_write_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_BITS-1:0] out_status,
  output logic [WORD_BITS-1:0]   out_read_word,
  output logic [LOST_BITS-1:0]   out_lost_count
);

  mqrf_cmd_t cmd;

  mqrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mqrf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .QUEUE_COUNT (QUEUE_COUNT),
    .WORD_BITS   (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_kind),
    .in_queue_select (in_queue_select),
    .in_write_word   (in_write_word),
    .out_status      (out_status),
    .out_read_word   (out_read_word),
    .out_lost_count  (out_lost_count)
  );

endmodule
